@@ hw/rtl/rsumt_pkg.sv @@
// rsumt_pkg: shared widths, command codes and defaults for the range sum tree.
// No dependencies; used by range_sum_tree_top.
package rsumt_pkg;

    // Field widths fixed by the transaction format
    localparam int POS_W  = 11;
    localparam int VAL_W  = 32;
    localparam int SUM_W  = 64;
    localparam int SIZE_W = 11;

    // Default tree capacity and reset value of the size register
    localparam int DEF_MAX_POSITIONS = 1024;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

    // Command codes
    localparam logic CMD_SET   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

endpackage

@@ hw/rtl/rsumt_ram.sv @@
// rsumt_ram: generic single-write, single-read RAM with a registered read.
// No dependencies; instantiated by range_sum_tree_top.
module rsumt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ hw/rtl/range_sum_tree_top.sv @@
// range_sum_tree_top: sum segment tree with point set and inclusive range query.
// Depends on rsumt_pkg and rsumt_ram (node sum store).
//
//  channel  signals                                                     direction
//  -------  ----------------------------------------------------------  ---------
//  in       in_valid, in_ready, cmd, first_index, last_index, new_value  input
//  out      out_valid, out_ready, sum_result                             output
//  cfg      cfg_wr_en, cfg_wr_data (size_in_use)                         input
//
// A query reads the node RAM through its read port level by level, at most two nodes
// per tree level. A set writes the leaf and each node on the path to the root,
// then runs a total-sum query over all active positions.
// After reset a clearing pass writes zero to all 2*MAX_POSITIONS nodes, one per
// cycle, with in_ready low. A waiting result stalls the sequencer only when a
// second result is ready to load; the next transaction is taken while one is held.
module range_sum_tree_top #(
    parameter int MAX_POSITIONS = rsumt_pkg::DEF_MAX_POSITIONS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          cfg_wr_en,
    input  logic [rsumt_pkg::SIZE_W-1:0]  cfg_wr_data,
    // input channel
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          cmd,
    input  logic [rsumt_pkg::POS_W-1:0]   first_index,
    input  logic [rsumt_pkg::POS_W-1:0]   last_index,
    input  logic signed [rsumt_pkg::VAL_W-1:0] new_value,
    // output channel
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [rsumt_pkg::SUM_W-1:0] sum_result
);

    localparam int DEPTH = 2 * MAX_POSITIONS;
    localparam int AW    = $clog2(DEPTH);
    localparam int NW    = $clog2(DEPTH + 1);
    localparam int SW    = rsumt_pkg::SUM_W;

    localparam logic [NW-1:0] LEAF_BASE = NW'(MAX_POSITIONS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [NW-1:0] ROOT      = NW'(1);

    // Sequencer states
    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_LEAF  = 3'd2;
    localparam logic [2:0] ST_UP    = 3'd3;
    localparam logic [2:0] ST_QA    = 3'd4;
    localparam logic [2:0] ST_QB    = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic [2:0]                     state_reg, state_next;
    logic [rsumt_pkg::SIZE_W-1:0]   size_reg;
    logic [AW-1:0]                  clr_reg, clr_next;
    logic [NW-1:0]                  a_reg, a_next;
    logic [NW-1:0]                  b_reg, b_next;
    logic [NW-1:0]                  k_reg, k_next;
    logic [SW-1:0]                  cur_reg, cur_next;
    logic [SW-1:0]                  acc_reg, acc_next;
    logic                           pend_reg, pend_next;
    logic                           out_valid_reg, out_valid_next;
    logic [SW-1:0]                  sum_reg, sum_next;

    // RAM port signals
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [SW-1:0] ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [SW-1:0] ram_rdata;

    // Input decode
    logic [31:0]   n32, lo32, hi32, lo_c, hi_c;
    logic [NW-1:0] n_act;
    logic          set_ok, query_empty;
    logic [SW-1:0] acc_sum, path_sum;
    logic [NW-1:0] parent;

    rsumt_ram #(
        .WIDTH (SW),
        .DEPTH (DEPTH)
    ) u_node_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Active size, clipped spans and range checks
    always_comb
    begin
        n32         = (32'(size_reg) > 32'(MAX_POSITIONS)) ? 32'(MAX_POSITIONS)
                                                           : 32'(size_reg);
        n_act       = NW'(n32);
        lo32        = 32'(first_index);
        hi32        = 32'(last_index);
        lo_c        = (lo32 == 32'd0) ? 32'd1 : lo32;
        hi_c        = (hi32 > n32) ? n32 : hi32;
        set_ok      = (lo32 != 32'd0) && (lo32 <= n32);
        query_empty = (n32 == 32'd0) || (lo_c > hi_c);
    end

    // Accumulate any read issued last cycle; path sum for updates
    assign acc_sum  = acc_reg + (pend_reg ? ram_rdata : '0);
    assign path_sum = cur_reg + ram_rdata;
    assign parent   = k_reg >> 1;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        k_next         = k_reg;
        cur_next       = cur_reg;
        acc_next       = acc_reg;
        pend_next      = 1'b0;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_raddr      = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (in_valid)
                begin
                    acc_next = '0;
                    if (n32 == 32'd0)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (cmd == rsumt_pkg::CMD_SET)
                    begin
                        if (set_ok)
                        begin
                            k_next     = LEAF_BASE + NW'(lo32) - NW'(1);
                            cur_next   = {{(SW - rsumt_pkg::VAL_W){new_value[rsumt_pkg::VAL_W-1]}},
                                          new_value};
                            state_next = ST_LEAF;
                        end
                        else
                        begin
                            a_next     = LEAF_BASE;
                            b_next     = LEAF_BASE + n_act;
                            state_next = ST_QA;
                        end
                    end
                    else if (query_empty)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        a_next     = LEAF_BASE + NW'(lo_c) - NW'(1);
                        b_next     = LEAF_BASE + NW'(hi_c);
                        state_next = ST_QA;
                    end
                end
            end

            // Write the leaf and fetch its sibling
            ST_LEAF:
            begin
                ram_we     = 1'b1;
                ram_waddr  = k_reg[AW-1:0];
                ram_wdata  = cur_reg;
                ram_re     = 1'b1;
                ram_raddr  = k_reg[AW-1:0] ^ AW'(1);
                state_next = ST_UP;
            end

            // One level per cycle: parent = path child + sibling
            ST_UP:
            begin
                ram_we    = 1'b1;
                ram_waddr = parent[AW-1:0];
                ram_wdata = path_sum;
                cur_next  = path_sum;
                k_next    = parent;
                if (parent == ROOT)
                begin
                    a_next     = LEAF_BASE;
                    b_next     = LEAF_BASE + n_act;
                    acc_next   = '0;
                    state_next = ST_QA;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = parent[AW-1:0] ^ AW'(1);
                end
            end

            // Query, left edge of the level
            ST_QA:
            begin
                acc_next = acc_sum;
                if (a_reg < b_reg)
                begin
                    if (a_reg[0])
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = a_reg[AW-1:0];
                        pend_next = 1'b1;
                        a_next    = a_reg + NW'(1);
                    end
                    state_next = ST_QB;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            // Query, right edge of the level, then climb
            ST_QB:
            begin
                acc_next = acc_sum;
                if (b_reg[0])
                begin
                    ram_re    = 1'b1;
                    ram_raddr = AW'(b_reg - NW'(1));
                    pend_next = 1'b1;
                end
                a_next     = a_reg >> 1;
                b_next     = b_reg >> 1;
                state_next = ST_QA;
            end

            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    sum_next       = acc_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            size_reg      <= rsumt_pkg::SIZE_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                size_reg <= cfg_wr_data;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        k_reg   <= k_next;
        cur_reg <= cur_next;
        acc_reg <= acc_next;
        sum_reg <= sum_next;
    end

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign sum_result = sum_reg;

endmodule
